FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the atomic memory operation unit.
// Has no dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AMOU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AMOU_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define AMOU_ASSERT(label, clk, rst, prop, msg)
`define AMOU_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

FILE: rtl/core/amou_pkg.sv
// Shared types, constants and helpers of the atomic memory operation unit.
// No dependencies; used by amou_exec and atomic_memory_op_unit.
package amou_pkg;

  localparam int MEM_WORDS_LOG2 = 10;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int WIDE_W = (MEM_WORDS_LOG2 > ADDR_W) ? MEM_WORDS_LOG2 : ADDR_W;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SWAP = 3'd1;
  localparam logic [2:0] OP_OR   = 3'd2;
  localparam logic [2:0] OP_LR   = 3'd3;
  localparam logic [2:0] OP_SC   = 3'd4;

  localparam logic [2:0] WIDTH_WORD   = 3'h2;
  localparam logic [2:0] WIDTH_DOUBLE = 3'h3;

  localparam logic [DATA_W-1:0] SC_FAIL = '1;

  typedef logic [MEM_WORDS_LOG2-1:0] mem_idx_t;

  typedef struct packed {
    logic              ill;
    logic              mem_we;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] value;
    logic              set_res;
    logic              clr_res;
  } amou_exec_t;

  // The address wraps when the memory is smaller than the address range.
  function automatic mem_idx_t to_index(input logic [ADDR_W-1:0] addr);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(addr);
    return wide[MEM_WORDS_LOG2-1:0];
  endfunction

endpackage

FILE: rtl/core/amou_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module amou_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/amou_exec.sv
// Operation decode, legality check and word combine for one atomic operation.
// Depends on amou_pkg.
module amou_exec (
  input  logic [2:0]                   func,
  input  logic [2:0]                   width_code,
  input  logic                         base_is_zero,
  input  logic                         source_is_zero,
  input  logic [amou_pkg::DATA_W-1:0]  old_word,
  input  logic [amou_pkg::DATA_W-1:0]  operand,
  input  logic                         res_hit,
  output amou_pkg::amou_exec_t         res
);

  logic width_ok;

  assign width_ok = (width_code == amou_pkg::WIDTH_WORD) ||
                    (width_code == amou_pkg::WIDTH_DOUBLE);

  always_comb begin
    res = '0;
    case (func)
      amou_pkg::OP_ADD: begin
        res.ill    = base_is_zero;
        res.mem_we = 1'b1;
        res.wdata  = old_word + operand;
        res.value  = old_word;
      end
      amou_pkg::OP_SWAP: begin
        res.ill    = base_is_zero;
        res.mem_we = 1'b1;
        res.wdata  = operand;
        res.value  = old_word;
      end
      amou_pkg::OP_OR: begin
        res.ill    = base_is_zero;
        res.mem_we = 1'b1;
        res.wdata  = old_word | operand;
        res.value  = old_word;
      end
      amou_pkg::OP_LR: begin
        res.ill     = !width_ok || !source_is_zero;
        res.set_res = 1'b1;
        res.value   = old_word;
      end
      amou_pkg::OP_SC: begin
        res.ill     = !width_ok;
        res.clr_res = 1'b1;
        res.mem_we  = res_hit;
        res.wdata   = operand;
        res.value   = res_hit ? '0 : amou_pkg::SC_FAIL;
      end
      default: begin
        res.ill = 1'b1;
      end
    endcase
    // An illegal operation has no side effects and returns zero.
    if (res.ill) begin
      res.mem_we  = 1'b0;
      res.set_res = 1'b0;
      res.clr_res = 1'b0;
      res.value   = '0;
    end
  end

endmodule

FILE: rtl/core/atomic_memory_op_unit.sv
// Atomic memory operation unit: the input is registered in stage one, the result in the output registers.
// Throughput one item per cycle while the output is not stalled; a read issued at accept, modify and
// write back when stage one fires; the last write, if to the same word, is forwarded from a bypass register.
// After reset the memory is cleared, one word per cycle, all 2**MEM_WORDS_LOG2 words
// (1024 at the default size); in_stall stays high during that pass.
`include "assert_macros.svh"

module atomic_memory_op_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          func,
  input  logic [2:0]                          width_code,
  input  logic                                base_is_zero,
  input  logic [amou_pkg::ADDR_W-1:0]         word_addr,
  input  logic [amou_pkg::DATA_W-1:0]         operand,
  input  logic                                source_is_zero,
  input  logic                                dest_is_zero,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [amou_pkg::DATA_W-1:0]         dest_value,
  output logic                                dest_write,
  output logic                                illegal
);

  logic                        clr_active;
  amou_pkg::mem_idx_t          clr_cnt;

  logic                        s1_valid;
  logic [2:0]                  s1_func;
  logic [2:0]                  s1_width;
  logic                        s1_base_zero;
  amou_pkg::mem_idx_t          s1_idx;
  logic [amou_pkg::DATA_W-1:0] s1_operand;
  logic                        s1_src_zero;
  logic                        s1_dst_zero;

  logic                        fwd_valid;
  amou_pkg::mem_idx_t          fwd_idx;
  logic [amou_pkg::DATA_W-1:0] fwd_data;

  logic                        res_valid;
  amou_pkg::mem_idx_t          res_idx;

  logic                        in_accept;
  logic                        adv;
  logic                        s1_fire;
  logic [amou_pkg::DATA_W-1:0] ram_rdata;
  logic [amou_pkg::DATA_W-1:0] old_word;
  logic                        res_hit;
  amou_pkg::amou_exec_t        ex;
  logic                        ram_we;
  amou_pkg::mem_idx_t          ram_waddr;
  logic [amou_pkg::DATA_W-1:0] ram_wdata;

  logic                        out_ill;
  logic                        s1_held;
  logic                        sc_done;

  assign adv       = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && adv;
  assign in_stall  = clr_active || (s1_valid && !adv);
  assign in_accept = in_valid && !in_stall;

  assign old_word = (fwd_valid && fwd_idx == s1_idx) ? fwd_data : ram_rdata;
  assign res_hit  = res_valid && (res_idx == s1_idx);

  assign ram_we    = clr_active || (s1_fire && ex.mem_we);
  assign ram_waddr = clr_active ? clr_cnt : s1_idx;
  assign ram_wdata = clr_active ? '0 : ex.wdata;

  assign out_ill = out_valid && illegal;
  assign s1_held = s1_valid && !adv;
  assign sc_done = s1_fire && s1_func == amou_pkg::OP_SC && !ex.ill;

  amou_ram #(
    .ADDR_BITS(amou_pkg::MEM_WORDS_LOG2),
    .DATA_BITS(amou_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (amou_pkg::to_index(word_addr)),
    .rdata (ram_rdata)
  );

  amou_exec u_exec (
    .func           (s1_func),
    .width_code     (s1_width),
    .base_is_zero   (s1_base_zero),
    .source_is_zero (s1_src_zero),
    .old_word       (old_word),
    .operand        (s1_operand),
    .res_hit        (res_hit),
    .res            (ex)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == '1) begin
          clr_active <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_fire && ex.mem_we) begin
        fwd_valid <= 1'b1;
      end
      if (s1_fire && ex.set_res) begin
        res_valid <= 1'b1;
      end else if (s1_fire && ex.clr_res) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func      <= func;
      s1_width     <= width_code;
      s1_base_zero <= base_is_zero;
      s1_idx       <= amou_pkg::to_index(word_addr);
      s1_operand   <= operand;
      s1_src_zero  <= source_is_zero;
      s1_dst_zero  <= dest_is_zero;
    end
    if (s1_fire) begin
      dest_value <= ex.value;
      dest_write <= !ex.ill && !s1_dst_zero;
      illegal    <= ex.ill;
    end
    if (s1_fire && ex.mem_we) begin
      fwd_idx  <= s1_idx;
      fwd_data <= ex.wdata;
    end
    if (s1_fire && ex.set_res) begin
      res_idx <= s1_idx;
    end
  end

  `AMOU_ASSERT(a_ill_no_write, clk, rst, out_ill |-> !dest_write && dest_value == '0, "bad illegal")
  `AMOU_ASSERT_NEXT(a_s1_hold, clk, rst, s1_held, s1_valid && $stable(s1_idx), "stage one lost")
  `AMOU_ASSERT_NEXT(a_sc_clears, clk, rst, sc_done, !res_valid, "reservation survived SC")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for atomic_memory_op_unit: a directed table, then random atomics.
// Known rows are checked to the table, others to a shadow memory and reservation kept here.
// Depends on amou_pkg and the atomic_memory_op_unit RTL.
module testbench;

  localparam logic [2:0] OP_RSVD_LO     = 3'd5;
  localparam logic [2:0] OP_RSVD_MID    = 3'd6;
  localparam logic [2:0] OP_RSVD_HI     = 3'd7;
  localparam logic [2:0] WIDTH_BYTE     = 3'h0;
  localparam logic [2:0] WIDTH_HALF     = 3'h1;
  localparam logic [2:0] WIDTH_CODE_MAX = 3'h7;

  localparam bit KNOWN     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  localparam int RANDOM_OPS   = 1125;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ITEM = 400;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 800;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOT_ADDRS    = 4;
  localparam int REPORT_MAX   = 10;

  typedef logic [amou_pkg::ADDR_W-1:0] addr_t;
  typedef logic [amou_pkg::DATA_W-1:0] data_t;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] width_code;
    logic       base_is_zero;
    addr_t      word_addr;
    data_t      operand;
    logic       source_is_zero;
    logic       dest_is_zero;
  } amo_req_t;

  typedef struct packed {
    data_t dest_value;
    logic  dest_write;
    logic  illegal;
  } amo_rsp_t;

  typedef struct packed {
    amo_req_t req;
    logic     typed;
    amo_rsp_t rsp;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] func;
  logic [2:0] width_code;
  logic       base_is_zero;
  addr_t      word_addr;
  data_t      operand;
  logic       source_is_zero;
  logic       dest_is_zero;
  logic       out_valid;
  logic       out_stall;
  data_t      dest_value;
  logic       dest_write;
  logic       illegal;

  data_t              shadow_mem [1 << amou_pkg::MEM_WORDS_LOG2];
  amou_pkg::mem_idx_t resv_idx;
  bit                 resv_valid;
  addr_t              last_lr_addr;

  amo_rsp_t   writeback_q[$];
  table_row_t directed_rows[$];
  int         items_sent = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         hold_done = 1'b0;

  atomic_memory_op_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .width_code     (width_code),
    .base_is_zero   (base_is_zero),
    .word_addr      (word_addr),
    .operand        (operand),
    .source_is_zero (source_is_zero),
    .dest_is_zero   (dest_is_zero),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dest_value     (dest_value),
    .dest_write     (dest_write),
    .illegal        (illegal)
  );

  always #1 clk = ~clk;

  function automatic bit calm_window();
    return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
  endfunction

  // Executes one atomic against the shadow state and returns the register writeback.
  function automatic amo_rsp_t amo_outcome(input amo_req_t r);
    amo_rsp_t           o;
    amou_pkg::mem_idx_t idx;
    data_t              old;
    bit                 width_ok;
    bit                 ill;
    idx = amou_pkg::to_index(r.word_addr);
    old = shadow_mem[idx];
    width_ok = (r.width_code == amou_pkg::WIDTH_WORD) ||
               (r.width_code == amou_pkg::WIDTH_DOUBLE);
    ill = 1'b0;
    o = '0;
    case (r.func)
      amou_pkg::OP_ADD, amou_pkg::OP_SWAP, amou_pkg::OP_OR: begin
        if (r.base_is_zero) begin
          ill = 1'b1;
        end else begin
          o.dest_value = old;
          case (r.func)
            amou_pkg::OP_ADD:  shadow_mem[idx] = old + r.operand;
            amou_pkg::OP_SWAP: shadow_mem[idx] = r.operand;
            default:           shadow_mem[idx] = old | r.operand;
          endcase
        end
      end
      amou_pkg::OP_LR: begin
        if (!width_ok || !r.source_is_zero) begin
          ill = 1'b1;
        end else begin
          resv_idx = idx;
          resv_valid = 1'b1;
          o.dest_value = old;
        end
      end
      amou_pkg::OP_SC: begin
        if (!width_ok) begin
          ill = 1'b1;
        end else begin
          if (resv_valid && resv_idx == idx) begin
            shadow_mem[idx] = r.operand;
            o.dest_value = '0;
          end else begin
            o.dest_value = amou_pkg::SC_FAIL;
          end
          resv_valid = 1'b0;
        end
      end
      default: ill = 1'b1;
    endcase
    if (ill) o = '0;
    o.illegal = ill;
    o.dest_write = !ill && !r.dest_is_zero;
    return o;
  endfunction

  function automatic void add_row(input logic [2:0] f, input logic [2:0] w, input int base0,
                                  input int addr, input data_t opnd,
                                  input int src0, input int dst0, input bit typed,
                                  input data_t val = '0, input bit ill = 1'b0);
    table_row_t row;
    row.req = '{func: f, width_code: w, base_is_zero: (base0 != 0),
                word_addr: addr[amou_pkg::ADDR_W-1:0], operand: opnd,
                source_is_zero: (src0 != 0), dest_is_zero: (dst0 != 0)};
    row.typed = typed;
    row.rsp = '{dest_value: val, dest_write: !ill && (dst0 == 0), illegal: ill};
    directed_rows.push_back(row);
  endfunction

  // Mostly legal traffic on a few hot words, with LR/SC pairs that hit their reservation.
  function automatic amo_req_t random_request();
    amo_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.func = 3'($urandom_range(0, OP_RSVD_HI));
      r.width_code = 3'($urandom_range(0, WIDTH_CODE_MAX));
      r.base_is_zero = 1'($urandom_range(0, 1));
      r.word_addr = addr_t'($urandom_range(0, (1 << amou_pkg::ADDR_W) - 1));
      r.operand = $urandom;
      r.source_is_zero = 1'($urandom_range(0, 1));
      r.dest_is_zero = 1'($urandom_range(0, 1));
      return r;
    end
    r.width_code = $urandom_range(0, 1) ? amou_pkg::WIDTH_WORD : amou_pkg::WIDTH_DOUBLE;
    r.base_is_zero = 1'b0;
    r.dest_is_zero = ($urandom_range(0, 9) == 0);
    r.source_is_zero = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.word_addr = addr_t'($urandom_range(0, HOT_ADDRS - 1));
    end else if (pick < 70) begin
      r.word_addr = last_lr_addr;
    end else begin
      r.word_addr = addr_t'($urandom_range(0, (1 << amou_pkg::ADDR_W) - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.func = 3'($urandom_range(amou_pkg::OP_ADD, amou_pkg::OP_OR));
    end else if (pick < 70) begin
      r.func = amou_pkg::OP_LR;
      r.source_is_zero = 1'b1;
      last_lr_addr = r.word_addr;
    end else begin
      r.func = amou_pkg::OP_SC;
      if (pick < 90) r.word_addr = last_lr_addr;
    end
    case ($urandom_range(0, 5))
      0:       r.operand = '0;
      1:       r.operand = '1;
      2:       r.operand = {1'b1, {(amou_pkg::DATA_W - 1){1'b0}}};
      default: r.operand = $urandom;
    endcase
    if (r.source_is_zero) r.operand = '0;
    return r;
  endfunction

  task automatic offer(input amo_req_t r, input bit typed, input amo_rsp_t typed_rsp);
    amo_rsp_t want;
    bit       taken;
    while (!calm_window() && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= r.func;
    width_code <= r.width_code;
    base_is_zero <= r.base_is_zero;
    word_addr <= r.word_addr;
    operand <= r.operand;
    source_is_zero <= r.source_is_zero;
    dest_is_zero <= r.dest_is_zero;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    want = amo_outcome(r);
    writeback_q.push_back(typed ? typed_rsp : want);
    items_sent++;
  endtask

  task automatic log_failure(input string why, input amo_rsp_t want, input amo_rsp_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t %s: expected value %h write %b illegal %b, got value %h write %b illegal %b",
               $realtime, why, want.dest_value, want.dest_write, want.illegal,
               got.dest_value, got.dest_write, got.illegal);
    end
  endtask

  // Result checking and the no-progress watchdog, sampled mid-cycle.
  always @(negedge clk) begin
    amo_rsp_t got;
    amo_rsp_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, writeback_q.size());
        $display("atomic_memory_op_unit verification failed");
        $finish;
      end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{dest_value: dest_value, dest_write: dest_write, illegal: illegal};
        if (writeback_q.size() == 0) begin
          log_failure("result with nothing outstanding", '0, got);
        end else begin
          want = writeback_q.pop_front();
          if (got.dest_value !== want.dest_value || got.dest_write !== want.dest_write ||
              got.illegal !== want.illegal) begin
            log_failure("writeback mismatch", want, got);
          end
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the unit up, and a calm stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm_window() && ($urandom_range(0, 99) < 15);
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = amou_pkg::OP_ADD;
    width_code = amou_pkg::WIDTH_WORD;
    base_is_zero = 1'b0;
    word_addr = '0;
    operand = '0;
    source_is_zero = 1'b0;
    dest_is_zero = 1'b0;
    resv_idx = '0;
    resv_valid = 1'b0;
    last_lr_addr = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    // func, width, base zero, addr, operand, source zero, dest zero, check, value, illegal
    add_row(amou_pkg::OP_ADD, WIDTH_BYTE, 0, 5, 32'hFFFF_FFFF, 0, 0, KNOWN, 32'h0);
    add_row(amou_pkg::OP_ADD, WIDTH_CODE_MAX, 0, 5, 32'h0000_0001, 0, 0, KNOWN, 32'hFFFF_FFFF);
    add_row(amou_pkg::OP_OR, amou_pkg::WIDTH_WORD, 0, 1023, 32'h8000_0001, 0, 0, KNOWN, 32'h0);
    add_row(amou_pkg::OP_SWAP, amou_pkg::WIDTH_DOUBLE, 0, 1023, 32'h0000_0000, 1, 0, PREDICTED);
    add_row(amou_pkg::OP_OR, WIDTH_HALF, 0, 1023, 32'h7FFF_FFFE, 0, 1, PREDICTED);
    add_row(amou_pkg::OP_ADD, amou_pkg::WIDTH_WORD, 1, 5, 32'h0000_0005, 0, 0, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_SWAP, amou_pkg::WIDTH_WORD, 1, 6, 32'hFFFF_FFFF, 0, 0, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_OR, amou_pkg::WIDTH_DOUBLE, 1, 7, 32'h0F0F_0F0F, 0, 1, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_LR, amou_pkg::WIDTH_WORD, 0, 0, 32'h0000_0000, 1, 0, KNOWN, 32'h0);
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_DOUBLE, 0, 0, 32'h1234_5678, 0, 0, KNOWN, 32'h0);
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_WORD, 0, 0, 32'h0000_0000, 0, 0, KNOWN,
            amou_pkg::SC_FAIL);
    add_row(amou_pkg::OP_LR, amou_pkg::WIDTH_DOUBLE, 0, 0, 32'h0000_0000, 1, 0, PREDICTED);
    add_row(amou_pkg::OP_LR, WIDTH_HALF, 0, 0, 32'h0000_0000, 1, 0, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_LR, amou_pkg::WIDTH_WORD, 0, 0, 32'h0000_0003, 0, 0, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_SC, WIDTH_CODE_MAX, 0, 0, 32'h5555_5555, 0, 0, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_WORD, 0, 0, 32'hAAAA_AAAA, 0, 0, PREDICTED);
    add_row(OP_RSVD_LO, amou_pkg::WIDTH_WORD, 0, 1, 32'h0000_0001, 0, 0, KNOWN, '0, 1'b1);
    add_row(OP_RSVD_MID, amou_pkg::WIDTH_DOUBLE, 0, 2, 32'hFFFF_FFFF, 1, 0, KNOWN, '0, 1'b1);
    add_row(OP_RSVD_HI, WIDTH_BYTE, 1, 1023, 32'h8000_0000, 0, 1, KNOWN, '0, 1'b1);
    add_row(amou_pkg::OP_LR, amou_pkg::WIDTH_DOUBLE, 0, 10, 32'h0000_0000, 1, 1, PREDICTED);
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_WORD, 0, 11, 32'hDEAD_BEEF, 0, 0, KNOWN,
            amou_pkg::SC_FAIL);
    add_row(amou_pkg::OP_LR, amou_pkg::WIDTH_WORD, 0, 20, 32'h0000_0000, 1, 0, PREDICTED);
    add_row(amou_pkg::OP_ADD, WIDTH_BYTE, 0, 20, 32'h0000_0003, 0, 0, PREDICTED);
    // The add above must not disturb the reservation, so this store still succeeds.
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_WORD, 0, 20, 32'h0000_0000, 1, 1, PREDICTED);
    add_row(amou_pkg::OP_SC, amou_pkg::WIDTH_DOUBLE, 1, 20, 32'h0000_0007, 0, 0, PREDICTED);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end
    repeat (RANDOM_OPS) offer(random_request(), PREDICTED, '0);
    in_valid <= 1'b0;

    while (writeback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("atomic_memory_op_unit verification clean");
    end else begin
      $display("atomic_memory_op_unit verification failed");
    end
    $finish;
  end

endmodule
